// File: rtl/imh_pkg.sv
// imh_pkg: constants, opcodes, status codes and sequencer states for indexed_max_heap.
// No dependencies.
`default_nettype none
package imh_pkg;
	localparam int CAPACITY = 64;
	localparam int KEY_SPACE = 256;
	localparam int PRI_W = 32;
	localparam int POS_W = $clog2(CAPACITY);
	localparam int CNT_W = POS_W + 1;
	localparam int KEY_W = 8;

	typedef enum logic [2:0] {
		OP_INSERT = 3'd0, OP_POP = 3'd1, OP_REM_POS = 3'd2, OP_REM_KEY = 3'd3,
		OP_PEEK = 3'd4, OP_LOOKUP = 3'd5, OP_UPDATE = 3'd6, OP_NONE = 3'd7
	} op_t;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NOTFOUND = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
	localparam logic [1:0] ST_DUP = 2'd3;

	typedef enum logic [3:0] {
		S_IDLE, S_RD, S_DECIDE, S_LAST, S_UP, S_UPCMP,
		S_DN, S_DNL, S_DNR, S_FIN, S_DONE
	} state_t;
endpackage
`default_nettype wire

// File: rtl/indexed_max_heap.sv
// indexed_max_heap: top level, sequencer, heap RAM and key position table.
// Depends on imh_pkg.
//
//  channel  | signals                                        | dir
//  command  | start, busy(out), op, key, priority_req, position | in
//  result   | done, status, out_key, out_priority,           | out
//           | out_position, count                            |
//
// One command at a time; busy stays high until the result strobe, which
// comes in the first idle cycle. Peek, lookup, failed ops and removal of
// the last entry only read and decide. Insert rises level by level toward
// the root. Remove with a moved entry and update: up phase as insert, then
// sink level by level until the entry settles. One heap RAM read a cycle
// sets the pace. Reset clears the count and all key valid bits at once.
// The receiver cannot stall: done is high for one cycle.
`default_nettype none
module indexed_max_heap import imh_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [2:0]         op,
	input  wire logic [KEY_W-1:0]   key,
	input  wire logic [PRI_W-1:0]   priority_req,
	input  wire logic [POS_W-1:0]   position,
	output logic                    done,
	output logic [1:0]              status,
	output logic [KEY_W-1:0]        out_key,
	output logic [PRI_W-1:0]        out_priority,
	output logic [POS_W-1:0]        out_position,
	output logic [CNT_W-1:0]        count
);
	// heap RAM: key and priority packed, one read and one write a cycle
	logic [KEY_W+PRI_W-1:0] heap_mem [CAPACITY];
	logic [KEY_W+PRI_W-1:0] rd_q;
	logic [POS_W-1:0] ra, wa;
	logic we;
	logic [KEY_W+PRI_W-1:0] wd;
	always_ff @(posedge clk) begin
		if (we) heap_mem[wa] <= wd;
		rd_q <= heap_mem[ra];
	end

	// key position table, valid bits in flops
	logic [POS_W-1:0] kpos_mem [KEY_SPACE];
	logic [KEY_SPACE-1:0] kvalid_q;
	logic kp_we;
	logic [KEY_W-1:0] kp_wk;
	logic [POS_W-1:0] kp_wd;
	logic [POS_W-1:0] kp_rd_q;
	always_ff @(posedge clk) begin
		if (kp_we) kpos_mem[kp_wk] <= kp_wd;
		kp_rd_q <= kpos_mem[key];
	end

	state_t state_q, state_d;
	op_t op_q;
	logic [KEY_W-1:0] key_q;
	logic [PRI_W-1:0] pri_q;
	logic [POS_W-1:0] pos_q;
	logic [CNT_W-1:0] cnt_q;
	// moving entry, kept in registers; its slot i is written at the end
	logic [KEY_W-1:0] ck_q;
	logic [PRI_W-1:0] cp_q;
	logic [POS_W-1:0] i_q;
	// left child seen during sift-down
	logic [KEY_W-1:0] bk_q;
	logic [PRI_W-1:0] bp_q;
	logic lw_q;
	logic done_q;
	logic [1:0] st_q;
	logic [KEY_W-1:0] rk_q;
	logic [PRI_W-1:0] rp_q;
	logic [POS_W-1:0] rpos_q;

	logic [POS_W-1:0] par;
	logic [CNT_W:0] lch, rch;
	logic [KEY_W-1:0] rd_k;
	logic [PRI_W-1:0] rd_p, thr;
	logic is_key_op, op_is_ins, pos_ok, kv_hit, rem_ok, rem_move, ins_ok;
	logic up_swap, dn_leaf, r_win;

	assign par = POS_W'((i_q - 1'b1) >> 1);
	assign lch = {1'b0, i_q, 1'b1};
	assign rch = lch + {{CNT_W{1'b0}}, 1'b1};
	assign rd_k = rd_q[PRI_W+:KEY_W];
	assign rd_p = rd_q[PRI_W-1:0];

	assign is_key_op = (op_q == OP_REM_KEY) || (op_q == OP_LOOKUP) || (op_q == OP_UPDATE);
	assign op_is_ins = (op_q == OP_INSERT);
	assign pos_ok = CNT_W'(pos_q) < cnt_q;
	assign kv_hit = kvalid_q[key_q];
	assign rem_ok = (op_q != OP_REM_KEY || kv_hit) && pos_ok;
	// a removed entry that is not the last leaves a hole for the last one
	assign rem_move = CNT_W'(pos_q) < cnt_q - 1'b1;
	assign ins_ok = !kv_hit && (cnt_q < CNT_W'(CAPACITY));
	// strict compares: ties never move an entry
	assign up_swap = rd_p < cp_q;
	assign dn_leaf = lch >= {1'b0, cnt_q};
	assign thr = lw_q ? bp_q : cp_q;
	assign r_win = (rch < {1'b0, cnt_q}) && (rd_p > thr);

	assign busy = (state_q != S_IDLE);
	assign count = cnt_q;
	assign done = done_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (start) state_d = S_RD;
			S_RD: state_d = S_DECIDE;
			S_DECIDE: begin
				state_d = S_DONE;
				unique case (op_q)
					OP_INSERT: if (ins_ok) state_d = S_UP;
					OP_POP, OP_REM_POS, OP_REM_KEY:
						if (rem_ok && rem_move) state_d = S_LAST;
					OP_UPDATE: if (kv_hit && pos_ok) state_d = S_UP;
					default: ;
				endcase
			end
			S_LAST: state_d = S_UP;
			S_UP: begin
				if (i_q != '0) state_d = S_UPCMP;
				else state_d = op_is_ins ? S_FIN : S_DN;
			end
			S_UPCMP: begin
				if (up_swap) state_d = S_UP;
				else state_d = op_is_ins ? S_FIN : S_DN;
			end
			S_DN: state_d = dn_leaf ? S_FIN : S_DNL;
			S_DNL: state_d = S_DNR;
			S_DNR: state_d = (r_win || lw_q) ? S_DN : S_FIN;
			S_FIN: state_d = S_IDLE;
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			kvalid_q <= '0;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= (state_q == S_FIN) || (state_q == S_DONE);
			unique case (state_q)
				S_IDLE: if (start) begin
					op_q <= op_t'(op); key_q <= key; pri_q <= priority_req;
					pos_q <= (op_t'(op) == OP_POP) ? '0 : position;
					st_q <= ST_NOTFOUND; rk_q <= '0; rp_q <= '0; rpos_q <= '0;
				end
				S_RD: if (is_key_op) pos_q <= kp_rd_q;
				S_DECIDE: begin
					unique case (op_q)
						OP_INSERT: begin
							if (kv_hit) st_q <= ST_DUP;
							else if (!ins_ok) st_q <= ST_FULL;
							else begin
								st_q <= ST_OK; rk_q <= key_q; rp_q <= pri_q;
								ck_q <= key_q; cp_q <= pri_q; i_q <= POS_W'(cnt_q);
								cnt_q <= cnt_q + 1'b1;
								kvalid_q[key_q] <= 1'b1;
							end
						end
						OP_POP, OP_REM_POS, OP_REM_KEY: if (rem_ok) begin
							st_q <= ST_OK; rk_q <= rd_k; rp_q <= rd_p;
							cnt_q <= cnt_q - 1'b1;
							kvalid_q[rd_k] <= 1'b0;
							i_q <= pos_q;
						end
						OP_PEEK: if (pos_ok) begin
							st_q <= ST_OK; rk_q <= rd_k; rp_q <= rd_p; rpos_q <= pos_q;
						end
						OP_LOOKUP: if (kv_hit && pos_ok) begin
							st_q <= ST_OK; rk_q <= key_q; rp_q <= rd_p; rpos_q <= pos_q;
						end
						OP_UPDATE: if (kv_hit && pos_ok) begin
							st_q <= ST_OK; rk_q <= key_q; rp_q <= pri_q;
							ck_q <= key_q; cp_q <= pri_q; i_q <= pos_q;
						end
						default: ;
					endcase
				end
				// rd_q holds the last entry; it fills the hole
				S_LAST: begin
					ck_q <= rd_k; cp_q <= rd_p;
				end
				S_UPCMP: if (up_swap) i_q <= par;
				S_DNL: begin
					bk_q <= rd_k; bp_q <= rd_p; lw_q <= rd_p > cp_q;
				end
				S_DNR: begin
					if (r_win) i_q <= POS_W'(rch);
					else if (lw_q) i_q <= POS_W'(lch);
				end
				S_FIN: if (op_q == OP_INSERT || op_q == OP_UPDATE) rpos_q <= i_q;
				default: ;
			endcase
		end
	end

	// memory port control: a moved neighbor is written into slot i,
	// the moving entry only once it has settled
	always_comb begin
		ra = pos_q; we = 1'b0; wa = i_q; wd = {ck_q, cp_q};
		kp_we = 1'b0; kp_wk = ck_q; kp_wd = i_q;
		unique case (state_q)
			S_RD: ra = is_key_op ? kp_rd_q : pos_q;
			S_DECIDE: ra = POS_W'(cnt_q - 1'b1);
			S_UP: ra = par;
			S_UPCMP: if (up_swap) begin
				we = 1'b1; wd = rd_q; kp_we = 1'b1; kp_wk = rd_k;
			end
			S_DN: ra = POS_W'(lch);
			S_DNL: ra = POS_W'(rch);
			S_DNR: begin
				if (r_win) begin
					we = 1'b1; wd = rd_q; kp_we = 1'b1; kp_wk = rd_k;
				end else if (lw_q) begin
					we = 1'b1; wd = {bk_q, bp_q}; kp_we = 1'b1; kp_wk = bk_q;
				end
			end
			S_FIN: begin
				we = 1'b1; kp_we = 1'b1;
			end
			default: ;
		endcase
	end

	assign status = st_q;
	assign out_key = rk_q;
	assign out_priority = rp_q;
	assign out_position = rpos_q;

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("done while busy");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CAPACITY)) else $error("count overflow");
	a_fail_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_OK) |-> $stable(count)) else $error("failed op changed count");
endmodule
`default_nettype wire
